// ===== sv/fsmatch_pkg.sv =====
package fsmatch_pkg;

  localparam int SYM_W = 8;
  localparam int POS_W = 12;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2,
    ACT_END     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_TOO_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    action_t          action;
    logic [SYM_W-1:0] symbol;
  } fsmatch_in_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
  } fsmatch_out_t;

  // Broadcast controls shared by every cell of the row
  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/fsmatch_cell.sv =====
module fsmatch_cell
  import fsmatch_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic             load_sel,
  input  logic [SYM_W-1:0] symbol,
  input  logic             match_in,
  output logic             match_out
);

  logic [SYM_W-1:0] pat_r;
  logic             match_r;
  logic             match_nxt;

  // Pattern byte holds no reset: only cells below the pattern length are used.
  always_ff @(posedge clk) begin
    if (ctrl.load && load_sel) begin
      pat_r <= symbol;
    end
  end

  // Partial match: neighbor matched the previous text byte and this byte fits here.
  always_comb begin
    match_nxt = match_r;
    if (ctrl.clear) begin
      match_nxt = 1'b0;
    end else if (ctrl.shift) begin
      match_nxt = match_in && (symbol == pat_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match_out = match_r;

endmodule

// ===== sv/first_substring_match.sv =====
// The result of an end-of-text transaction is registered and shown at out in the next cycle.
// Throughput: one transaction per cycle while no held result waits on out_ready; every text
// byte is compared against all PATTERN_MAX pattern cells of the row at once, the partial match moving one cell a byte.
// Reset (rst_n low, synchronous): lengths, match record, cell match flags and the
// output valid flag are cleared; pattern bytes in the cells are left as they are.
module first_substring_match
  import fsmatch_pkg::*;
#(
  parameter int PATTERN_MAX = 128,
  parameter int TEXT_MAX    = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  fsmatch_in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output fsmatch_out_t out_data
);

  localparam int PLW = $clog2(PATTERN_MAX + 1);
  localparam int TLW = $clog2(TEXT_MAX + 1);
  localparam int CW  = (TLW > PLW) ? TLW : PLW;

  logic [PLW-1:0] pat_len_r, pat_len_nxt;
  logic [TLW-1:0] text_len_r, text_len_nxt;
  logic           found_r, found_nxt;
  logic [CW-1:0]  start_r, start_nxt;
  logic           out_valid_r, out_valid_nxt;
  fsmatch_out_t   out_data_r, out_data_nxt;

  logic                   accept;
  logic                   load_ok;
  logic                   shift_ok;
  cell_ctrl_t             ctrl;
  logic [PATTERN_MAX-1:0] load_sel;
  logic [PATTERN_MAX-1:0] last_cell;
  logic [PATTERN_MAX-1:0] match;
  logic [PATTERN_MAX:0]   chain;
  logic                   hit_now;
  logic [CW-1:0]          cur_start;
  logic                   eff_found;
  logic [CW-1:0]          eff_start;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign load_ok  = (text_len_r == '0) && (pat_len_r < PLW'(PATTERN_MAX));
  assign shift_ok = (text_len_r < TLW'(TEXT_MAX));

  assign ctrl.clear = accept && (in_data.action == ACT_CLEAR);
  assign ctrl.load  = accept && (in_data.action == ACT_PATTERN) && load_ok;
  assign ctrl.shift = accept && (in_data.action == ACT_TEXT) && shift_ok;

  assign chain[0] = 1'b1;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    assign load_sel[k]  = (pat_len_r == PLW'(k));
    assign last_cell[k] = (pat_len_r == PLW'(k + 1));

    fsmatch_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load_sel  (load_sel[k]),
      .symbol    (in_data.symbol),
      .match_in  (chain[k]),
      .match_out (match[k])
    );

    assign chain[k+1] = match[k];
  end

  // Whole pattern matched at the text byte taken most recently.
  assign hit_now   = |(match & last_cell);
  assign cur_start = CW'(text_len_r) - CW'(pat_len_r);
  assign eff_found = found_r || hit_now;
  assign eff_start = found_r ? start_r : cur_start;

  always_comb begin
    pat_len_nxt   = pat_len_r;
    text_len_nxt  = text_len_r;
    found_nxt     = eff_found;
    start_nxt     = eff_start;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (accept) begin
      unique case (in_data.action)
        ACT_CLEAR: begin
          pat_len_nxt  = '0;
          text_len_nxt = '0;
          found_nxt    = 1'b0;
          start_nxt    = '0;
        end
        ACT_PATTERN: begin
          if (load_ok) begin
            pat_len_nxt = pat_len_r + PLW'(1);
          end
        end
        ACT_TEXT: begin
          if (shift_ok) begin
            text_len_nxt = text_len_r + TLW'(1);
          end
        end
        ACT_END: begin
          out_valid_nxt = 1'b1;
          priority if (CW'(pat_len_r) > CW'(text_len_r)) begin
            out_data_nxt.status   = STAT_TOO_LONG;
            out_data_nxt.position = '0;
          end else if (pat_len_r == '0) begin
            out_data_nxt.status   = STAT_FOUND;
            out_data_nxt.position = '0;
          end else if (eff_found) begin
            out_data_nxt.status   = STAT_FOUND;
            out_data_nxt.position = POS_W'(eff_start);
          end else begin
            out_data_nxt.status   = STAT_NOT_FOUND;
            out_data_nxt.position = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      text_len_r  <= '0;
      found_r     <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pat_len_r   <= pat_len_nxt;
      text_len_r  <= text_len_nxt;
      found_r     <= found_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A recorded match needs a nonempty pattern that fits in the text seen so far.
  a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (pat_len_r != '0) && (CW'(pat_len_r) <= CW'(text_len_r)))
    else $error("match recorded without a fitting pattern");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (pat_len_r == '0) && (text_len_r == '0) && !found_r)
    else $error("clear transaction left state behind");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != STAT_FOUND)) |-> (out_data_r.position == '0))
    else $error("nonzero position without a match");

  a_pattern_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    ((text_len_r != '0) && !ctrl.clear) |=> $stable(pat_len_r))
    else $error("pattern length changed during text");

endmodule

// ===== dv/fsmatch_checker.sv =====
module fsmatch_checker
  import fsmatch_pkg::*;
#(
  parameter int PATTERN_MAX = 128,
  parameter int TEXT_MAX    = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  fsmatch_in_t  in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  fsmatch_out_t out_data,
  output int           mismatches,
  output int           awaiting
);

  logic [SYM_W-1:0] pat_bytes [PATTERN_MAX];
  logic [SYM_W-1:0] text_ring [PATTERN_MAX];
  int unsigned      pat_len;
  int unsigned      text_len;
  bit               hit;
  int unsigned      hit_start;
  fsmatch_out_t     search_results [$];
  int               fail_cnt = 0;
  int               open_cnt = 0;

  assign mismatches = fail_cnt;
  assign awaiting   = open_cnt;

  function automatic void clear_search();
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_bytes[i] = '0;
      text_ring[i] = '0;
    end
    pat_len   = 0;
    text_len  = 0;
    hit       = 1'b0;
    hit_start = 0;
  endfunction

  // pattern against the last pat_len text bytes held in the ring
  function automatic bit tail_hits();
    int unsigned base_idx;
    base_idx = text_len - pat_len;
    for (int unsigned k = 0; k < pat_len; k++) begin
      if (text_ring[(base_idx + k) % PATTERN_MAX] != pat_bytes[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit search_step(input fsmatch_in_t t, output fsmatch_out_t res);
    res = '0;
    case (t.action)
      ACT_CLEAR: clear_search();
      ACT_PATTERN: begin
        // pattern is frozen once text has started
        if (text_len == 0 && pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = t.symbol;
          pat_len++;
        end
      end
      ACT_TEXT: begin
        if (text_len < TEXT_MAX) begin
          text_ring[text_len % PATTERN_MAX] = t.symbol;
          text_len++;
          if (!hit && pat_len > 0 && text_len >= pat_len) begin
            if (tail_hits()) begin
              hit       = 1'b1;
              hit_start = text_len - pat_len;
            end
          end
        end
      end
      ACT_END: begin
        if (pat_len > text_len) begin
          res.status = STAT_TOO_LONG;
        end else if (pat_len == 0) begin
          res.status = STAT_FOUND;
        end else if (hit) begin
          res.status   = STAT_FOUND;
          res.position = hit_start[POS_W-1:0];
        end else begin
          res.status = STAT_NOT_FOUND;
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    fsmatch_out_t res;
    fsmatch_out_t want;
    if (!rst_n) begin
      clear_search();
      search_results.delete();
    end else begin
      // push before pop so a same-cycle result still finds its expectation
      if (in_valid && in_ready) begin
        if (search_step(in_data, res)) search_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (search_results.size() == 0) begin
          fail_cnt++;
          $error("unexpected result transaction: status %0d position %0d",
                 out_data.status, out_data.position);
        end else begin
          want = search_results.pop_front();
          if (out_data.status !== want.status) begin
            fail_cnt++;
            $error("status: expected %0d, got %0d", want.status, out_data.status);
          end
          if (out_data.position !== want.position) begin
            fail_cnt++;
            $error("position: expected %0d, got %0d", want.position, out_data.position);
          end
        end
      end
    end
    open_cnt = search_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import fsmatch_pkg::*;

  localparam int PATTERN_MAX = 128;
  localparam int TEXT_MAX    = 4096;

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         in_valid  = 1'b0;
  logic         in_ready;
  fsmatch_in_t  in_data   = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  fsmatch_out_t out_data;
  int           mismatches;
  int           awaiting;
  int           idle_pct   = 0;
  int           stall_pct  = 0;
  int           item_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_substring_match #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  fsmatch_checker #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) match_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input action_t act, input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, symbol: sym};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    item_count++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // clear, pattern, text (optionally with the pattern planted), end (sometimes a second end)
  task automatic run_search(input int plen, input int tlen, input int plant, input int alpha_n);
    logic [SYM_W-1:0] alpha [4];
    logic [SYM_W-1:0] pat [$];
    logic [SYM_W-1:0] sym;
    for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
    send_item(ACT_CLEAR, 8'($urandom));
    for (int i = 0; i < plen; i++) begin
      pat.push_back(alpha[$urandom_range(alpha_n - 1)]);
      send_item(ACT_PATTERN, pat[i]);
    end
    for (int i = 0; i < tlen; i++) begin
      if (plant >= 0 && i >= plant && i < plant + plen) sym = pat[i - plant];
      else sym = alpha[$urandom_range(alpha_n - 1)];
      send_item(ACT_TEXT, sym);
      // stray pattern bytes and early ends inside the text
      if ($urandom_range(99) < 4) send_item(ACT_PATTERN, 8'($urandom));
      if ($urandom_range(99) < 4) send_item(ACT_END, 8'($urandom));
    end
    send_item(ACT_END, 8'($urandom));
    if ($urandom_range(3) == 0) send_item(ACT_END, 8'($urandom));
  endtask

  task automatic random_phase(input int n_items);
    int plen;
    int tlen;
    int plant;
    int stop_at;
    stop_at = item_count + n_items;
    while (item_count < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 8)) send_item(action_t'($urandom_range(3)), 8'($urandom));
      end else begin
        plen  = ($urandom_range(9) == 0) ? $urandom_range(7, 130) : $urandom_range(0, 6);
        tlen  = ($urandom_range(14) == 0) ? $urandom_range(120, 300) : $urandom_range(0, 30);
        plant = (plen <= tlen && $urandom_range(99) < 60) ? $urandom_range(tlen - plen) : -1;
        run_search(plen, tlen, plant, $urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern, empty text, straight out of reset; then a pattern longer than the text until the text catches up
    send_item(ACT_END, 8'h00);
    send_item(ACT_CLEAR, 8'hFF);
    send_item(ACT_PATTERN, 8'h00);
    send_item(ACT_PATTERN, 8'hFF);
    send_item(ACT_END, 8'h00);
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_END, 8'hFF);
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_END, 8'h00);
    send_item(ACT_PATTERN, 8'h55);
    send_item(ACT_TEXT, 8'hAA);
    send_item(ACT_END, 8'h00);
    // miss, then text after the end completes a match
    send_item(ACT_CLEAR, 8'h5A);
    send_item(ACT_PATTERN, 8'hA5);
    send_item(ACT_TEXT, 8'h5A);
    send_item(ACT_TEXT, 8'h5A);
    send_item(ACT_END, 8'h00);
    send_item(ACT_TEXT, 8'hA5);
    send_item(ACT_END, 8'h00);
    send_item(ACT_END, 8'h3C);
    send_item(ACT_CLEAR, 8'h00);
    send_item(ACT_TEXT, 8'h11);
    send_item(ACT_END, 8'h00);

    // pattern overflow, planted match well past the first window of text
    run_search(130, 200, 60, 2);
    // one-byte pattern hit late in a long run of other bytes
    send_item(ACT_CLEAR, 8'h00);
    send_item(ACT_PATTERN, 8'hC3);
    repeat (199) send_item(ACT_TEXT, 8'h3C);
    repeat (3) send_item(ACT_TEXT, 8'hC3);
    send_item(ACT_END, 8'h00);
    wait_results();

    item_count = 0;
    random_phase(400);
    wait_results();
    idle_pct = 45;
    random_phase(400);
    wait_results();
    idle_pct  = 0;
    stall_pct = 45;
    random_phase(400);
    wait_results();
    idle_pct  = 20;
    stall_pct = 20;
    random_phase(400);
    wait_results();

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
